// ===== src/sync_length_sum_frame_parser_assert.svh =====
// ----------------------------------------------------------------------------
// sync length sum frame parser assertion macros
// shared property forms for the frame parser checks
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_SUM_FRAME_PARSER_ASSERT_SVH
`define SYNC_LENGTH_SUM_FRAME_PARSER_ASSERT_SVH

// same-cycle implication
`define SLFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// next-cycle implication
`define SLFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

// ===== src/slfp_pkg.sv =====
// ----------------------------------------------------------------------------
// slfp_pkg
// types and constants shared by the frame parser modules
// ----------------------------------------------------------------------------
package slfp_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1
  } cfg_idx_t;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h66;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hCC;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LENH  = 3'd2,
    PH_LENL  = 3'd3,
    PH_TYPE  = 3'd4,
    PH_BODY  = 3'd5,
    PH_CHKH  = 3'd6,
    PH_CHKL  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2,
    ST_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic [7:0] body_index;
    status_t    frame_status;
    logic [7:0] frame_type;
    logic [8:0] body_length;
  } result_t;

endpackage

// ===== src/slfp_cfg.sv =====
// ----------------------------------------------------------------------------
// slfp_cfg
// sync byte registers, written through the configuration channel
// ----------------------------------------------------------------------------
module slfp_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [slfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output logic [7:0]                    sync_first,
  output logic [7:0]                    sync_second
);
  import slfp_pkg::*;

  logic wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (wr_en) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/slfp_core.sv =====
// ----------------------------------------------------------------------------
// slfp_core
// frame parser state machine, advances one byte per step
// ----------------------------------------------------------------------------
module slfp_core #(
  parameter int unsigned MAX_BODY = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        sync_first,
  input  logic [7:0]        sync_second,
  output slfp_pkg::result_t res
);
  import slfp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_BODY + 1);

  phase_t        phase, phase_next;
  logic [15:0]   frame_length, frame_length_next;
  logic [CW-1:0] body_count, body_count_next;
  logic [15:0]   running_sum, running_sum_next;
  logic [7:0]    type_held, type_held_next;
  logic [7:0]    check_high, check_high_next;

  logic [15:0]   sum_add;
  logic [CW-1:0] count_inc;
  logic [15:0]   blen_cur;
  logic [15:0]   blen_next;

  function automatic logic [15:0] body_len_of(input logic [15:0] len);
    body_len_of = (len <= 16'd1) ? 16'd0 : (len - 16'd1);
  endfunction

  assign sum_add   = running_sum + {8'd0, rx_byte};
  assign count_inc = body_count + CW'(1);
  assign blen_cur  = body_len_of(frame_length);
  assign blen_next = body_len_of(frame_length_next);

  // next state
  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    body_count_next   = body_count;
    running_sum_next  = running_sum;
    type_held_next    = type_held;
    check_high_next   = check_high;
    if (step) begin
      case (phase)
        PH_SYNC1: begin
          if (rx_byte == sync_first) begin
            running_sum_next = {8'd0, rx_byte};
            body_count_next  = '0;
            phase_next       = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (rx_byte == sync_second) begin
            running_sum_next = sum_add;
            phase_next       = PH_LENH;
          end else begin
            phase_next = PH_SYNC1;
          end
        end
        PH_LENH: begin
          frame_length_next = {rx_byte, 8'd0};
          running_sum_next  = sum_add;
          phase_next        = PH_LENL;
        end
        PH_LENL: begin
          frame_length_next = {frame_length[15:8], rx_byte};
          running_sum_next  = sum_add;
          if (body_len_of({frame_length[15:8], rx_byte}) > 16'(MAX_BODY)) begin
            phase_next = PH_SYNC1;
          end else begin
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_held_next   = rx_byte;
          running_sum_next = sum_add;
          body_count_next  = '0;
          phase_next       = (blen_cur == 16'd0) ? PH_CHKH : PH_BODY;
        end
        PH_BODY: begin
          running_sum_next = sum_add;
          body_count_next  = count_inc;
          if (16'(count_inc) >= blen_cur) begin
            phase_next = PH_CHKH;
          end
        end
        PH_CHKH: begin
          check_high_next = rx_byte;
          phase_next      = PH_CHKL;
        end
        PH_CHKL: begin
          phase_next = PH_SYNC1;
        end
        default: begin
          phase_next = PH_SYNC1;
        end
      endcase
    end
  end

  // result word for this byte
  always_comb begin
    res              = '0;
    res.frame_status = ST_BUSY;
    case (phase)
      PH_LENL: begin
        if (blen_next > 16'(MAX_BODY)) begin
          res.frame_status = ST_LONG;
        end
      end
      PH_BODY: begin
        res.body_valid = 1'b1;
        res.body_byte  = rx_byte;
        res.body_index = 8'(body_count);
      end
      PH_CHKL: begin
        res.frame_status = ({check_high, rx_byte} == running_sum) ? ST_GOOD : ST_BAD;
      end
      default: ;
    endcase
    res.frame_type  = type_held_next;
    res.body_length = (blen_next > 16'd511) ? 9'd511 : blen_next[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      frame_length <= '0;
      body_count   <= '0;
      running_sum  <= '0;
      type_held    <= '0;
      check_high   <= '0;
    end else begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      body_count   <= body_count_next;
      running_sum  <= running_sum_next;
      type_held    <= type_held_next;
      check_high   <= check_high_next;
    end
  end

endmodule

// ===== src/sync_length_sum_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sync_length_sum_frame_parser
// Takes one received byte per word and finds frames of the form: two sync
// bytes, 16-bit big-endian length L, type byte, L-1 body bytes, 16-bit
// big-endian checksum (byte sum mod 65536 of all earlier frame bytes). Every
// input word yields exactly one output word carrying body byte and index,
// frame status, held type and body length. Throughput is one byte per clock
// while the output is not stalled: a byte is registered on acceptance,
// passes through the parser state logic and lands in the output register,
// where its result is offered. The input register and the output register
// let a new byte enter while a finished result waits to be taken.
// Sync bytes are written through the configuration channel, which is always
// ready.
// ----------------------------------------------------------------------------
`include "sync_length_sum_frame_parser_assert.svh"

module sync_length_sum_frame_parser #(
  parameter int unsigned MAX_BODY = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           body_valid,
  output logic [7:0]                     body_byte,
  output logic [7:0]                     body_index,
  output logic [1:0]                     frame_status,
  output logic [7:0]                     frame_type,
  output logic [8:0]                     body_length,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [slfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import slfp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_adv;
  logic       step;
  logic       in_take;
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  result_t    res;
  result_t    out_res;

  slfp_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sync_first  (sync_first),
    .sync_second (sync_second)
  );

  slfp_core #(
    .MAX_BODY (MAX_BODY)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (s1_byte),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .res         (res)
  );

  // output register free or being drained this cycle
  assign s1_adv   = !out_valid || !out_stall;
  assign step     = s1_valid && s1_adv;
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign body_valid   = out_res.body_valid;
  assign body_byte    = out_res.body_byte;
  assign body_index   = out_res.body_index;
  assign frame_status = out_res.frame_status;
  assign frame_type   = out_res.frame_type;
  assign body_length  = out_res.body_length;

  `SLFP_ASSERT_IMPLY(a_body_busy, clk, rst, out_valid && body_valid, frame_status == ST_BUSY)
  `SLFP_ASSERT_IMPLY(a_idle_zero, clk, rst, out_valid && !body_valid,
                     body_byte == 8'd0 && body_index == 8'd0)
  `SLFP_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_byte))
  `SLFP_ASSERT_NEXT(a_step_out, clk, rst, step, out_valid)

endmodule

// ===== verif/tb_sync_length_sum_frame_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_length_sum_frame_parser
// Sends byte streams of sync, length, type, body and checksum words through
// the frame parser with random gaps and output stalls, keeps its own frame
// parser state to predict every output word, and checks each one field by
// field. Sync bytes are reprogrammed between traffic phases.
// ----------------------------------------------------------------------------
module tb_sync_length_sum_frame_parser;
  import slfp_pkg::*;

  localparam int unsigned MAX_BODY      = 256;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte   = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 body_valid;
  logic [7:0]           body_byte;
  logic [7:0]           body_index;
  logic [1:0]           frame_status;
  logic [7:0]           frame_type;
  logic [8:0]           body_length;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = 8'h00;

  sync_length_sum_frame_parser #(
    .MAX_BODY(MAX_BODY)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .body_valid   (body_valid),
    .body_byte    (body_byte),
    .body_index   (body_index),
    .frame_status (frame_status),
    .frame_type   (frame_type),
    .body_length  (body_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser state mirrored by the testbench
  logic [7:0]  sync1_reg;
  logic [7:0]  sync2_reg;
  phase_t      cur_phase;
  logic [15:0] len_reg;
  logic [8:0]  body_cnt;
  logic [15:0] byte_sum;
  logic [7:0]  type_reg;
  logic [7:0]  chk_hi_reg;

  result_t     frame_results_q[$];
  int unsigned errors     = 0;
  int unsigned bytes_sent = 0;
  bit          tx_idle    = 1'b1;
  bit          rx_idle    = 1'b1;
  int unsigned rx_wait    = 0;
  int unsigned hold_left  = 0;

  task automatic reset_model;
    sync1_reg  = SYNC_FIRST_RST;
    sync2_reg  = SYNC_SECOND_RST;
    cur_phase  = PH_SYNC1;
    len_reg    = '0;
    body_cnt   = '0;
    byte_sum   = '0;
    type_reg   = '0;
    chk_hi_reg = '0;
  endtask

  function automatic logic [16:0] body_len_of_frame(input logic [15:0] l);
    return (l <= 16'd1) ? 17'd0 : {1'b0, l} - 17'd1;
  endfunction

  function automatic result_t parse_rx_byte(input logic [7:0] b);
    result_t     r;
    logic [16:0] blen;
    r = '0;
    r.frame_status = ST_BUSY;
    case (cur_phase)
      PH_SYNC1: begin
        if (b == sync1_reg) begin
          byte_sum  = {8'h00, b};
          body_cnt  = '0;
          cur_phase = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        // a wrong second sync is not retried as a first sync
        if (b == sync2_reg) begin
          byte_sum  = byte_sum + {8'h00, b};
          cur_phase = PH_LENH;
        end else begin
          cur_phase = PH_SYNC1;
        end
      end
      PH_LENH: begin
        len_reg   = {b, 8'h00};
        byte_sum  = byte_sum + {8'h00, b};
        cur_phase = PH_LENL;
      end
      PH_LENL: begin
        len_reg[7:0] = b;
        byte_sum     = byte_sum + {8'h00, b};
        if (body_len_of_frame(len_reg) > 17'(MAX_BODY)) begin
          r.frame_status = ST_LONG;
          cur_phase      = PH_SYNC1;
        end else begin
          cur_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_reg  = b;
        byte_sum  = byte_sum + {8'h00, b};
        body_cnt  = '0;
        cur_phase = (body_len_of_frame(len_reg) == 17'd0) ? PH_CHKH : PH_BODY;
      end
      PH_BODY: begin
        r.body_valid = 1'b1;
        r.body_byte  = b;
        r.body_index = body_cnt[7:0];
        byte_sum     = byte_sum + {8'h00, b};
        body_cnt     = body_cnt + 9'd1;
        if ({8'h00, body_cnt} >= body_len_of_frame(len_reg)) begin
          cur_phase = PH_CHKH;
        end
      end
      PH_CHKH: begin
        chk_hi_reg = b;
        cur_phase  = PH_CHKL;
      end
      PH_CHKL: begin
        r.frame_status = ({chk_hi_reg, b} == byte_sum) ? ST_GOOD : ST_BAD;
        cur_phase      = PH_SYNC1;
      end
      default: begin
        cur_phase = PH_SYNC1;
      end
    endcase
    blen = body_len_of_frame(len_reg);
    r.frame_type  = type_reg;
    r.body_length = (blen > 17'd511) ? 9'd511 : blen[8:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frame_results_q.size() == 0) begin
        $display("%0t: output word with nothing expected, expected none actual status %0d",
                 $time, frame_status);
        errors++;
      end else begin
        want = frame_results_q.pop_front();
        check_field("body_valid", 9'(want.body_valid), 9'(body_valid));
        check_field("body_byte", 9'(want.body_byte), 9'(body_byte));
        check_field("body_index", 9'(want.body_index), 9'(body_index));
        check_field("frame_status", 9'(want.frame_status), 9'(frame_status));
        check_field("frame_type", 9'(want.frame_type), 9'(frame_type));
        check_field("body_length", want.body_length, body_length);
      end
      rx_wait = rx_idle ? $urandom_range(0, 12) : 0;
    end
  end

  // output stall: long hold first, then the per-word wait
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_wait != 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    frame_results_q.push_back(parse_rx_byte(b));
    bytes_sent++;
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SYNC_FIRST) begin
      sync1_reg = val;
    end else begin
      sync2_reg = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // fill below zero gives random body bytes
  task automatic send_frame(input logic [15:0] len, input logic [7:0] ftype,
                            input int fill, input bit corrupt);
    logic [15:0] sum;
    logic [7:0]  b;
    int unsigned nbody;
    nbody = (len <= 16'd1) ? 0 : len - 1;
    sum = {8'h00, sync1_reg};
    send_byte(sync1_reg);
    sum = sum + {8'h00, sync2_reg};
    send_byte(sync2_reg);
    sum = sum + {8'h00, len[15:8]};
    send_byte(len[15:8]);
    sum = sum + {8'h00, len[7:0]};
    send_byte(len[7:0]);
    if (nbody > MAX_BODY) return;
    sum = sum + {8'h00, ftype};
    send_byte(ftype);
    for (int i = 0; i < nbody; i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
      sum = sum + {8'h00, b};
      send_byte(b);
    end
    if (corrupt) sum = sum ^ (16'd1 << $urandom_range(0, 15));
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
  endtask

  task automatic send_wrong_sync;
    logic [7:0] b;
    send_byte(sync1_reg);
    do b = 8'($urandom); while (b == sync2_reg);
    send_byte(b);
  endtask

  task automatic test_short_frames;
    send_frame(16'd0, 8'h00, -1, 1'b0);
    send_frame(16'd2, 8'hA5, 8'hFF, 1'b0);
  endtask

  task automatic test_bad_checksum;
    send_frame(16'd1, 8'hFF, -1, 1'b1);
  endtask

  task automatic test_long_length;
    send_frame(16'(MAX_BODY + 2), 8'h00, -1, 1'b0);
    send_frame(16'hFFFF, 8'h00, -1, 1'b0);
  endtask

  task automatic test_sync_hunt;
    // repeated first sync fails as second sync, then the second sync is ignored
    send_byte(sync1_reg);
    send_byte(sync1_reg);
    send_byte(sync2_reg);
    send_wrong_sync;
  endtask

  task automatic test_backpressure;
    drain_results;
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    hold_left = 60;
    send_frame(16'd40, 8'h3C, -1, 1'b0);
    drain_results;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_traffic;
    logic [7:0]  first_set[5]  = '{8'h00, 8'hFF, 8'h5A, 8'h00, SYNC_FIRST_RST};
    logic [7:0]  second_set[5] = '{8'hFF, 8'h00, 8'h5A, 8'h00, SYNC_SECOND_RST};
    logic [7:0]  b;
    logic [15:0] len;
    int unsigned pick;
    int unsigned stop_at;
    for (int p = 0; p < 5; p++) begin
      drain_results;
      if (p == 3) begin
        first_set[p]  = 8'($urandom);
        second_set[p] = 8'($urandom);
      end
      write_config(CFG_SYNC_FIRST, first_set[p]);
      write_config(CFG_SYNC_SECOND, second_set[p]);
      if (p == 0) send_frame(16'(MAX_BODY + 1), 8'($urandom), -1, 1'b0);
      stop_at = bytes_sent + 75;
      while (bytes_sent < stop_at) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        len = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(25, MAX_BODY + 1))
                                           : 16'($urandom_range(0, 24));
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          repeat ($urandom_range(1, 6)) begin
            do b = 8'($urandom); while (b == sync1_reg);
            send_byte(b);
          end
        end else if (pick == 2) begin
          send_wrong_sync;
        end else if (pick == 3) begin
          send_frame(16'($urandom_range(MAX_BODY + 2, 65535)), 8'($urandom), -1, 1'b0);
        end else begin
          send_frame(len, 8'($urandom), -1, pick < 6);
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    reset_model;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_short_frames;
    test_bad_checksum;
    test_long_length;
    test_sync_hunt;
    test_backpressure;
    test_random_traffic;
    drain_results;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
